/* hdl/bwf_pkg.sv */
// Shared types and constants for the Butterworth IIR filter bank.
// Used by bwf_coef_regs, bwf_mac and the top level.
`default_nettype none

package bwf_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int COEF_BITS    = 32;
    localparam int FRAC_BITS    = COEF_BITS - 2;
    localparam int NUM_COEFS    = 8;
    localparam int CFG_IDX_BITS = $clog2(NUM_COEFS);
    localparam int PROD_BITS    = COEF_BITS + SAMPLE_BITS;
    // five products plus rounding term need three guard bits
    localparam int ACC_BITS     = PROD_BITS + 3;
    localparam int QUOT_BITS    = ACC_BITS - FRAC_BITS;

    localparam logic [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        {{(ACC_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        FUNC_FIRST  = 2'd0,
        FUNC_SECOND = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CI_FIRST_B0  = 3'd0,
        CI_FIRST_B1  = 3'd1,
        CI_FIRST_A1  = 3'd2,
        CI_SECOND_B0 = 3'd3,
        CI_SECOND_B1 = 3'd4,
        CI_SECOND_B2 = 3'd5,
        CI_SECOND_A1 = 3'd6,
        CI_SECOND_A2 = 3'd7
    } coef_idx_t;

    typedef struct packed {
        logic [COEF_BITS-1:0] first_b0;
        logic [COEF_BITS-1:0] first_b1;
        logic [COEF_BITS-1:0] first_a1;
        logic [COEF_BITS-1:0] second_b0;
        logic [COEF_BITS-1:0] second_b1;
        logic [COEF_BITS-1:0] second_b2;
        logic [COEF_BITS-1:0] second_a1;
        logic [COEF_BITS-1:0] second_a2;
    } coef_set_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] first_prev_in;
        logic [SAMPLE_BITS-1:0] first_prev_out;
        logic [SAMPLE_BITS-1:0] second_in_1;
        logic [SAMPLE_BITS-1:0] second_in_2;
        logic [SAMPLE_BITS-1:0] second_out_1;
        logic [SAMPLE_BITS-1:0] second_out_2;
    } hist_t;

endpackage

`default_nettype wire

/* hdl/bwf_coef_regs.sv */
// Coefficient register file (Q2.30) written through the config channel.
// Depends on bwf_pkg.
`default_nettype none

module bwf_coef_regs
    import bwf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire logic [CFG_IDX_BITS-1:0] wr_index,
    input  wire logic [COEF_BITS-1:0]    wr_data,
    output coef_set_t                    coefs
);

    coef_set_t coef_reg;
    coef_set_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            case (coef_idx_t'(wr_index))
                CI_FIRST_B0:  coef_next.first_b0  = wr_data;
                CI_FIRST_B1:  coef_next.first_b1  = wr_data;
                CI_FIRST_A1:  coef_next.first_a1  = wr_data;
                CI_SECOND_B0: coef_next.second_b0 = wr_data;
                CI_SECOND_B1: coef_next.second_b1 = wr_data;
                CI_SECOND_B2: coef_next.second_b2 = wr_data;
                CI_SECOND_A1: coef_next.second_a1 = wr_data;
                CI_SECOND_A2: coef_next.second_a2 = wr_data;
                default:      coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg           <= '0;
            coef_reg.first_b0  <= COEF_ONE;
            coef_reg.second_b0 <= COEF_ONE;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

`default_nettype wire

/* hdl/bwf_mac.sv */
// Sum of products for the selected section, round to nearest and saturate.
// Five parallel multipliers shared by both sections. Depends on bwf_pkg.
`default_nettype none

module bwf_mac
    import bwf_pkg::*;
(
    input  wire logic [1:0]               func,
    input  wire logic [SAMPLE_BITS-1:0]   sample,
    input  wire coef_set_t                coefs,
    input  wire hist_t                    hist,
    output logic      [SAMPLE_BITS-1:0]   y
);

    logic signed [COEF_BITS-1:0]   c0, c1, c2, c3, c4;
    logic signed [SAMPLE_BITS-1:0] d0, d1, d2, d3, d4;
    logic signed [PROD_BITS-1:0]   p0, p1, p2, p3, p4;
    logic signed [ACC_BITS-1:0]    sum;
    logic [QUOT_BITS-1:0]          quot;
    logic [QUOT_BITS-SAMPLE_BITS:0] top_bits;

    // slots 2 and 4 are the subtracted feedback terms
    always_comb
    begin
        c0 = '0; c1 = '0; c2 = '0; c3 = '0; c4 = '0;
        d0 = sample; d1 = '0; d2 = '0; d3 = '0; d4 = '0;
        case (func_t'(func))
            FUNC_SECOND:
            begin
                c0 = coefs.second_b0;
                c1 = coefs.second_b1; d1 = hist.second_in_1;
                c2 = coefs.second_a1; d2 = hist.second_out_1;
                c3 = coefs.second_b2; d3 = hist.second_in_2;
                c4 = coefs.second_a2; d4 = hist.second_out_2;
            end
            default:
            begin
                c0 = coefs.first_b0;
                c1 = coefs.first_b1;  d1 = hist.first_prev_in;
                c2 = coefs.first_a1;  d2 = hist.first_prev_out;
            end
        endcase
    end

    assign p0 = c0 * d0;
    assign p1 = c1 * d1;
    assign p2 = c2 * d2;
    assign p3 = c3 * d3;
    assign p4 = c4 * d4;

    assign sum = ACC_BITS'(p0) + ACC_BITS'(p1) + ACC_BITS'(p3)
               - ACC_BITS'(p2) - ACC_BITS'(p4) + ROUND_HALF;

    // floor of the rounded sum: arithmetic shift by the fraction width
    assign quot     = sum[ACC_BITS-1:FRAC_BITS];
    assign top_bits = quot[QUOT_BITS-1:SAMPLE_BITS-1];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
            y = quot[SAMPLE_BITS-1:0];
        else if (quot[QUOT_BITS-1])
            y = SAT_MIN;
        else
            y = SAT_MAX;
    end

endmodule

`default_nettype wire

/* hdl/butterworth_iir_filter_bank_unit.sv */
// Top level of the two-section IIR filter bank: input register, histories,
// result register. Depends on bwf_pkg, bwf_coef_regs and bwf_mac.
`default_nettype none

// Filter bank with a first-order and a second-order direct-form-I section,
// each with its own history. func 0 filters through the first-order section,
// func 1 through the biquad, func 2 clears both histories (no result), func 3
// does nothing. While the output side does not stall, one item per clock is
// sustained, including back-to-back items on the same section: the rounding,
// saturation and multiply-accumulate sit combinationally between the input
// register and the result register, and the histories are updated in the same
// cycle the result is registered. A result item waits in the input register
// while the output side stalls. Coefficients are Q2.30 and should be written
// only while the block is idle; cfg_ready is always high.
module butterworth_iir_filter_bank_unit
    import bwf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              func,
    input  wire logic [SAMPLE_BITS-1:0]  sample,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic      [SAMPLE_BITS-1:0]  filtered,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [COEF_BITS-1:0]    cfg_data
);

    coef_set_t              coefs;
    logic                   s1_valid_reg, s1_valid_next;
    func_t                  s1_func_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    hist_t                  hist_reg, hist_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] filtered_reg;
    logic [SAMPLE_BITS-1:0] mac_y;
    logic                   in_xfer;
    logic                   has_result;
    logic                   out_free;
    logic                   s1_go;

    assign cfg_ready = 1'b1;

    bwf_coef_regs u_coef_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coefs    (coefs)
    );

    bwf_mac u_mac (
        .func   (s1_func_reg),
        .sample (s1_sample_reg),
        .coefs  (coefs),
        .hist   (hist_reg),
        .y      (mac_y)
    );

    assign has_result = (s1_func_reg == FUNC_FIRST) || (s1_func_reg == FUNC_SECOND);
    assign out_free   = !out_valid_reg || !out_stall;
    // items without a result retire without waiting on the output side
    assign s1_go      = s1_valid_reg && (!has_result || out_free);
    assign in_stall   = s1_valid_reg && !s1_go;
    assign in_xfer    = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_go && has_result)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;

        hist_next = hist_reg;
        if (s1_go)
        begin
            case (s1_func_reg)
                FUNC_FIRST:
                begin
                    hist_next.first_prev_in  = s1_sample_reg;
                    hist_next.first_prev_out = mac_y;
                end
                FUNC_SECOND:
                begin
                    hist_next.second_in_2  = hist_reg.second_in_1;
                    hist_next.second_in_1  = s1_sample_reg;
                    hist_next.second_out_2 = hist_reg.second_out_1;
                    hist_next.second_out_1 = mac_y;
                end
                FUNC_CLEAR: hist_next = '0;
                default:    hist_next = hist_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_func_reg   <= func_t'(func);
            s1_sample_reg <= sample;
        end
        if (s1_go && has_result)
            filtered_reg <= mac_y;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

`ifndef SYNTH
    a_clear_zeroes_hist: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_func_reg == FUNC_CLEAR) |=> (hist_reg == '0))
        else $error("history not cleared after clear item");

    a_first_feedback: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_func_reg == FUNC_FIRST) |=> (hist_reg.first_prev_out == filtered_reg))
        else $error("first-order feedback differs from result");

    a_second_feedback: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_func_reg == FUNC_SECOND) |=> (hist_reg.second_out_1 == filtered_reg))
        else $error("second-order feedback differs from result");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a staged item");
`endif

endmodule

`default_nettype wire

/* sim/butterworth_iir_filter_bank_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for butterworth_iir_filter_bank_unit: a directed table, then
// random sample runs under several coefficient sets, checked against a local filter model.
// Depends on bwf_pkg and the filter bank RTL.

module butterworth_iir_filter_bank_unit_tb;
    import bwf_pkg::*;

    localparam int     CYCLE_LIMIT     = 200_000;
    localparam int     DRAIN_CYCLES    = 4;
    localparam int     END_CYCLES      = 10;
    localparam int     NUM_PHASES      = 7;
    localparam int     ITEMS_PER_PHASE = 70;
    localparam int     NUM_ROWS        = 35;
    localparam int     LONG_HOLD       = 120;
    localparam int     HOLD_AFTER      = 150;
    localparam longint Y_HI            = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint Y_LO            = -Y_HI - 1;
    localparam longint HALF_LSB        = 64'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic { ROW_ITEM, ROW_COEF } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        coef_idx_t             reg_idx;
        logic [COEF_BITS-1:0]  reg_data;
        func_t                 op;
        logic [SAMPLE_BITS-1:0] x;
        bit                    typed;
        logic [SAMPLE_BITS-1:0] want;
    } stim_row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    func_t                   func      = FUNC_FIRST;
    logic [SAMPLE_BITS-1:0]  sample    = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [SAMPLE_BITS-1:0]  filtered;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COEF_BITS-1:0]    cfg_data  = '0;

    // filter model state
    logic signed [COEF_BITS-1:0]   coef_model [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] first_x1, first_y1;
    logic signed [SAMPLE_BITS-1:0] second_x1, second_x2, second_y1, second_y2;

    logic [SAMPLE_BITS-1:0] expected_filtered [$];
    logic [SAMPLE_BITS-1:0] head_filtered;
    stim_row_t              directed_rows [NUM_ROWS];
    int                     error_count  = 0;
    int                     results_seen = 0;
    int                     cycle_count  = 0;

    butterworth_iir_filter_bank_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("butterworth_iir_filter_bank_unit_tb: done, errors");
            $finish;
        end
    end

    function automatic longint coef_times(logic signed [COEF_BITS-1:0] c,
                                          logic signed [SAMPLE_BITS-1:0] s);
        return longint'(c) * longint'(s);
    endfunction

    // round half up at the Q2.30 point, then clamp to the sample range
    function automatic logic [SAMPLE_BITS-1:0] round_clamp(longint acc);
        longint q;
        q = (acc + HALF_LSB) >>> FRAC_BITS;
        if (q > Y_HI)
            q = Y_HI;
        if (q < Y_LO)
            q = Y_LO;
        return q[SAMPLE_BITS-1:0];
    endfunction

    task automatic filter_predict(input func_t op, input logic signed [SAMPLE_BITS-1:0] x,
                                  output bit produces, output logic [SAMPLE_BITS-1:0] y);
        longint acc;
        produces = 1'b0;
        y        = '0;
        case (op)
            FUNC_FIRST:
            begin
                acc = coef_times(coef_model[CI_FIRST_B0], x)
                    + coef_times(coef_model[CI_FIRST_B1], first_x1)
                    - coef_times(coef_model[CI_FIRST_A1], first_y1);
                y        = round_clamp(acc);
                first_x1 = x;
                first_y1 = y;
                produces = 1'b1;
            end
            FUNC_SECOND:
            begin
                acc = coef_times(coef_model[CI_SECOND_B0], x)
                    + coef_times(coef_model[CI_SECOND_B1], second_x1)
                    + coef_times(coef_model[CI_SECOND_B2], second_x2)
                    - coef_times(coef_model[CI_SECOND_A1], second_y1)
                    - coef_times(coef_model[CI_SECOND_A2], second_y2);
                y         = round_clamp(acc);
                second_x2 = second_x1;
                second_x1 = x;
                second_y2 = second_y1;
                second_y1 = y;
                produces  = 1'b1;
            end
            FUNC_CLEAR:
            begin
                first_x1  = '0;
                first_y1  = '0;
                second_x1 = '0;
                second_x2 = '0;
                second_y1 = '0;
                second_y2 = '0;
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 64)) - 16'd32;
            3, 4:    return 16'($urandom_range(0, 8191)) - 16'd4096;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] butter_coef(int idx);
        case (idx)
            0, 1:    return 32'sd146813000;
            2:       return -32'sd780120000;
            3, 5:    return 32'sd72477573;
            4:       return 32'sd144848772;
            6:       return -32'sd1227286905;
            default: return 32'sd443240625;
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] phase_coef(int ph, int idx);
        case (ph)
            0:       return butter_coef(idx);
            2:       return 32'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic stim_row_t item_row(func_t op, logic [SAMPLE_BITS-1:0] x, bit typed,
                                           logic [SAMPLE_BITS-1:0] want);
        stim_row_t r;
        r = '{ROW_ITEM, CI_FIRST_B0, '0, op, x, typed, want};
        return r;
    endfunction

    function automatic stim_row_t coef_row(coef_idx_t idx, logic [COEF_BITS-1:0] data);
        stim_row_t r;
        r = '{ROW_COEF, idx, data, FUNC_NONE, '0, 1'b0, '0};
        return r;
    endfunction

    // offer one item and hold it until the transfer; queue what it should produce
    task automatic send_item(input func_t op, input logic [SAMPLE_BITS-1:0] x, input bit calm,
                             input bit typed, input logic [SAMPLE_BITS-1:0] want);
        int                     gap;
        bit                     produces;
        logic [SAMPLE_BITS-1:0] y;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        sample   <= x;
        do
            @(posedge clk);
        while (in_stall);
        filter_predict(op, x, produces, y);
        if (produces)
            expected_filtered.push_back(typed ? want : y);
    endtask

    // clear and no-op items leave nothing queued, so allow for the pipeline too
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // caller drops cfg_valid after the last write
    task automatic write_coef(input coef_idx_t idx, input logic [COEF_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        coef_model[idx] = data;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_filtered.size() == 0)
            begin
                $display("%0t: filtered %0d arrived with nothing expected",
                         $time, $signed(filtered));
                error_count++;
            end
            else
            begin
                head_filtered = expected_filtered.pop_front();
                if (filtered !== head_filtered)
                begin
                    $display("%0t: filtered expected %0d, got %0d",
                             $time, $signed(head_filtered), $signed(filtered));
                    error_count++;
                end
            end
        end
    end

    // result side back-pressure, including one long hold so the input side backs up
    initial
    begin : result_sink
        int  hold_left;
        int  calm_left;
        int  r;
        bit  long_hold_done;
        hold_left      = 0;
        calm_left      = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                out_stall      <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    calm_left = $urandom_range(20, 80);
                else if (r >= 98)
                    hold_left = $urandom_range(20, 40);
                else if (r >= 90)
                    hold_left = $urandom_range(3, 10);
                else if (r >= 60)
                    hold_left = $urandom_range(0, 2);
                out_stall <= (r >= 60);
            end
        end
    end

    initial
    begin : stimulus
        func_t run_op;
        int    run_len;
        int    sent;
        int    r;
        bit    calm;
        bit    paused;

        for (int i = 0; i < NUM_COEFS; i++)
            coef_model[i] = '0;
        coef_model[CI_FIRST_B0]  = COEF_ONE;
        coef_model[CI_SECOND_B0] = COEF_ONE;
        first_x1  = '0;
        first_y1  = '0;
        second_x1 = '0;
        second_x2 = '0;
        second_y1 = '0;
        second_y2 = '0;
        paused    = 1'b0;

        directed_rows = '{
            // unity gain after reset: output equals input
            item_row(FUNC_FIRST,  16'h0000, 1'b1, 16'h0000),
            item_row(FUNC_FIRST,  16'h7FFF, 1'b1, 16'h7FFF),
            item_row(FUNC_FIRST,  16'h8000, 1'b1, 16'h8000),
            item_row(FUNC_SECOND, 16'h0001, 1'b1, 16'h0001),
            item_row(FUNC_SECOND, 16'hFFFF, 1'b1, 16'hFFFF),
            item_row(FUNC_SECOND, 16'h7FFF, 1'b1, 16'h7FFF),
            item_row(FUNC_CLEAR,  16'h5A5A, 1'b0, 16'h0000),
            item_row(FUNC_NONE,   16'hFFFF, 1'b0, 16'h0000),
            item_row(FUNC_FIRST,  16'h1234, 1'b1, 16'h1234),
            // gain near +2 and -2 saturates both ways
            coef_row(CI_FIRST_B0, 32'h7FFF_FFFF),
            item_row(FUNC_FIRST,  16'h7FFF, 1'b1, 16'h7FFF),
            item_row(FUNC_FIRST,  16'h8000, 1'b1, 16'h8000),
            coef_row(CI_FIRST_B0, 32'h8000_0000),
            item_row(FUNC_FIRST,  16'h7FFF, 1'b1, 16'h8000),
            item_row(FUNC_FIRST,  16'h8000, 1'b1, 16'h7FFF),
            // gain 0.5: halves round toward plus infinity
            coef_row(CI_FIRST_B0, 32'h2000_0000),
            item_row(FUNC_FIRST,  16'h0001, 1'b1, 16'h0001),
            item_row(FUNC_FIRST,  16'hFFFF, 1'b1, 16'h0000),
            item_row(FUNC_FIRST,  16'h0003, 1'b1, 16'h0002),
            item_row(FUNC_FIRST,  16'hFFFD, 1'b1, 16'hFFFF),
            // extreme history weights, saturated feedback
            coef_row(CI_FIRST_B1,  32'h7FFF_FFFF),
            coef_row(CI_FIRST_A1,  32'h8000_0000),
            coef_row(CI_SECOND_B1, 32'h8000_0000),
            coef_row(CI_SECOND_B2, 32'h7FFF_FFFF),
            coef_row(CI_SECOND_A1, 32'h7FFF_FFFF),
            coef_row(CI_SECOND_A2, 32'h8000_0000),
            item_row(FUNC_FIRST,  16'h4000, 1'b0, 16'h0000),
            item_row(FUNC_FIRST,  16'hC000, 1'b0, 16'h0000),
            item_row(FUNC_SECOND, 16'h2000, 1'b0, 16'h0000),
            item_row(FUNC_SECOND, 16'h9000, 1'b0, 16'h0000),
            item_row(FUNC_SECOND, 16'h7FFF, 1'b0, 16'h0000),
            // after a clear only the current-sample weight counts
            item_row(FUNC_CLEAR,  16'h0000, 1'b0, 16'h0000),
            item_row(FUNC_SECOND, 16'h0064, 1'b1, 16'h0064),
            item_row(FUNC_FIRST,  16'hFF38, 1'b1, 16'hFF9C),
            item_row(FUNC_FIRST,  16'h7FFF, 1'b0, 16'h0000)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_COEF)
            begin
                wait_idle();
                write_coef(directed_rows[i].reg_idx, directed_rows[i].reg_data);
                cfg_valid <= 1'b0;
            end
            else
                send_item(directed_rows[i].op, directed_rows[i].x, 1'b0,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            for (int i = 0; i < NUM_COEFS; i++)
                write_coef(coef_idx_t'(i), phase_coef(ph, i));
            cfg_valid <= 1'b0;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    run_op = FUNC_FIRST;
                else if (r < 90)
                    run_op = FUNC_SECOND;
                else if (r < 97)
                    run_op = FUNC_CLEAR;
                else
                    run_op = FUNC_NONE;
                run_len = (run_op == FUNC_FIRST || run_op == FUNC_SECOND) ?
                          $urandom_range(1, 16) : 1;
                calm    = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < run_len; k++)
                begin
                    send_item(run_op, rand_sample(), calm, 1'b0, '0);
                    if (run_op != FUNC_NONE)
                        sent++;
                end
                // one full drain with the sender quiet
                if (ph == 3 && !paused && sent >= 35)
                begin
                    paused = 1'b1;
                    wait_idle();
                end
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("butterworth_iir_filter_bank_unit_tb: done, clean");
        else
            $display("butterworth_iir_filter_bank_unit_tb: done, errors");
        $finish;
    end

endmodule
